// ----- rtl/core/pgmp5_pkg.sv -----
// Shared types and constants for the PGM P5 stream parser.
// Holds the parse phase enum, result codes, character codes and the result record.
// No dependencies.
package pgmp5_pkg;

  localparam int ACC_W = 17;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;
  localparam logic [ACC_W-1:0] MAXVAL_MAX = 17'd255;

  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_5     = 8'h35;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef enum logic [2:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_HEADER,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_PIXEL,
    KIND_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    ERR_MAGIC,
    ERR_TOKEN,
    ERR_RANGE,
    ERR_SHORT
  } err_t;

  typedef enum logic [1:0] {
    FLD_WIDTH,
    FLD_HEIGHT,
    FLD_MAXVAL
  } field_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  pixel_value;
    logic        last_pixel;
    err_t        error_code;
  } result_t;

endpackage

// ----- rtl/core/pgmp5_if.sv -----
// Valid/ready stream interfaces for the PGM P5 parser: input bytes and results.
// Depends on pgmp5_pkg for the result code types.
interface pgmp5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface pgmp5_out_if;
  logic                valid;
  logic                ready;
  pgmp5_pkg::kind_t    result_kind;
  logic [15:0]         image_width;
  logic [15:0]         image_height;
  logic [7:0]          pixel_value;
  logic                last_pixel;
  pgmp5_pkg::err_t     error_code;

  modport source (output valid, output result_kind, output image_width,
                  output image_height, output pixel_value, output last_pixel,
                  output error_code, input ready);
  modport sink (input valid, input result_kind, input image_width,
                input image_height, input pixel_value, input last_pixel,
                input error_code, output ready);
endinterface

// ----- rtl/core/pgm_p5_stream_parser_unit.sv -----
// Top level of the PGM P5 stream parser: header parse, validation and pixel pass-through.
// Depends on pgmp5_pkg and the stream interfaces in pgmp5_if.sv.
// A result is registered into the output slot, or into the skid slot while the output slot is full.
// Throughput: one beat per cycle while input ready is high; the header multiply and the times-ten
// step each sit between the state registers, and a two-slot output register keeps input flowing.
// Input ready drops only while both output slots hold results.
// Reset (synchronous, active high) returns the parser to the first magic byte and empties the output.
module pgm_p5_stream_parser_unit #(
  parameter int DIM_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  pgmp5_in_if.sink           in_stream,
  pgmp5_out_if.source        out_stream
);
  import pgmp5_pkg::*;

  localparam int PIX_W = 2 * DIM_BITS;

  phase_t              phase, phase_next;
  field_t              field_idx, field_idx_next;
  logic                in_number, in_number_next;
  logic                in_comment, in_comment_next;
  logic [ACC_W-1:0]    acc, acc_next;
  logic [DIM_BITS-1:0] width_store, width_store_next;
  logic [DIM_BITS-1:0] height_store, height_store_next;
  logic [PIX_W-1:0]    pixels_left, pixels_left_next;

  logic                out_valid, skid_valid;
  result_t             out_data, skid_data;
  result_t             res;
  logic                res_valid;

  logic                accept, produce;
  logic [7:0]          c;
  logic                is_digit, is_ws;
  logic [3:0]          digit;
  logic [ACC_W+3:0]    acc_wide;
  logic [ACC_W-1:0]    acc_sat;
  logic                dim_bad, maxval_bad;
  logic [PIX_W-1:0]    area;

  assign in_stream.ready = !skid_valid;
  assign accept   = in_stream.valid && !skid_valid;
  assign produce  = accept && res_valid;
  assign c        = in_stream.data_byte;
  assign is_digit = (c >= CHAR_0) && (c <= CHAR_9);
  assign is_ws    = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  assign digit    = 4'(c - CHAR_0);
  assign acc_wide = ((ACC_W+4)'(acc) << 3) + ((ACC_W+4)'(acc) << 1) + (ACC_W+4)'(digit);
  assign acc_sat  = (acc_wide > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : acc_wide[ACC_W-1:0];
  assign dim_bad    = (acc == '0) || (|acc[ACC_W-1:DIM_BITS]);
  assign maxval_bad = (acc == '0) || (acc > MAXVAL_MAX);
  assign area     = PIX_W'(width_store) * PIX_W'(height_store);

  always_comb begin
    phase_next        = phase;
    field_idx_next    = field_idx;
    in_number_next    = in_number;
    in_comment_next   = in_comment;
    acc_next          = acc;
    width_store_next  = width_store;
    height_store_next = height_store;
    pixels_left_next  = pixels_left;
    if (accept) begin
      if (in_stream.end_of_file) begin
        phase_next        = PH_MAGIC0;
        field_idx_next    = FLD_WIDTH;
        in_number_next    = 1'b0;
        in_comment_next   = 1'b0;
        acc_next          = '0;
        width_store_next  = '0;
        height_store_next = '0;
        pixels_left_next  = '0;
      end else begin
        unique case (phase)
          PH_MAGIC0: phase_next = (c == CHAR_P) ? PH_MAGIC1 : PH_IDLE;
          PH_MAGIC1: phase_next = (c == CHAR_5) ? PH_HEADER : PH_IDLE;
          PH_HEADER: begin
            priority if (in_number) begin
              if (is_digit) begin
                acc_next = acc_sat;
              end else begin
                in_number_next = 1'b0;
                acc_next       = '0;
                unique case (field_idx)
                  FLD_WIDTH: begin
                    if (dim_bad) begin
                      phase_next = PH_IDLE;
                    end else begin
                      width_store_next = acc[DIM_BITS-1:0];
                      field_idx_next   = FLD_HEIGHT;
                    end
                  end
                  FLD_HEIGHT: begin
                    if (dim_bad) begin
                      phase_next = PH_IDLE;
                    end else begin
                      height_store_next = acc[DIM_BITS-1:0];
                      field_idx_next    = FLD_MAXVAL;
                    end
                  end
                  default: begin
                    if (maxval_bad) begin
                      phase_next = PH_IDLE;
                    end else begin
                      field_idx_next   = FLD_WIDTH;
                      pixels_left_next = area;
                      phase_next       = PH_PIXELS;
                    end
                  end
                endcase
              end
            end else if (in_comment) begin
              if (c == CHAR_LF) begin
                in_comment_next = 1'b0;
              end
            end else if (is_ws) begin
              phase_next = PH_HEADER;
            end else if (c == CHAR_HASH) begin
              in_comment_next = 1'b1;
            end else if (is_digit) begin
              in_number_next = 1'b1;
              acc_next       = ACC_W'(digit);
            end else begin
              phase_next = PH_IDLE;
            end
          end
          PH_PIXELS: begin
            pixels_left_next = pixels_left - PIX_W'(1);
            if (pixels_left == PIX_W'(1)) begin
              phase_next = PH_IDLE;
            end
          end
          PH_IDLE: phase_next = PH_IDLE;
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '{result_kind: KIND_ERROR, image_width: '0, image_height: '0,
                  pixel_value: '0, last_pixel: 1'b0, error_code: ERR_MAGIC};
    if (in_stream.end_of_file) begin
      unique case (phase)
        PH_MAGIC0, PH_MAGIC1: begin
          res_valid      = 1'b1;
          res.error_code = ERR_MAGIC;
        end
        PH_HEADER: begin
          res_valid = 1'b1;
          if (in_number && (field_idx == FLD_MAXVAL)) begin
            res.error_code = maxval_bad ? ERR_RANGE : ERR_SHORT;
          end else begin
            res.error_code = ERR_TOKEN;
          end
        end
        PH_PIXELS: begin
          res_valid      = 1'b1;
          res.error_code = ERR_SHORT;
        end
        default: res_valid = 1'b0;
      endcase
    end else begin
      unique case (phase)
        PH_MAGIC0: begin
          res_valid      = (c != CHAR_P);
          res.error_code = ERR_MAGIC;
        end
        PH_MAGIC1: begin
          res_valid      = (c != CHAR_5);
          res.error_code = ERR_MAGIC;
        end
        PH_HEADER: begin
          priority if (in_number) begin
            if (!is_digit) begin
              if (field_idx == FLD_WIDTH || field_idx == FLD_HEIGHT) begin
                res_valid      = dim_bad;
                res.error_code = ERR_RANGE;
              end else if (maxval_bad) begin
                res_valid      = 1'b1;
                res.error_code = ERR_RANGE;
              end else begin
                res_valid        = 1'b1;
                res.result_kind  = KIND_HEADER;
                res.image_width  = 16'(width_store);
                res.image_height = 16'(height_store);
              end
            end
          end else if (!in_comment && !is_ws && (c != CHAR_HASH) && !is_digit) begin
            res_valid      = 1'b1;
            res.error_code = ERR_TOKEN;
          end
        end
        PH_PIXELS: begin
          res_valid       = 1'b1;
          res.result_kind = KIND_PIXEL;
          res.pixel_value = c;
          res.last_pixel  = (pixels_left == PIX_W'(1));
        end
        default: res_valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC0;
      field_idx    <= FLD_WIDTH;
      in_number    <= 1'b0;
      in_comment   <= 1'b0;
      acc          <= '0;
      width_store  <= '0;
      height_store <= '0;
      pixels_left  <= '0;
    end else begin
      phase        <= phase_next;
      field_idx    <= field_idx_next;
      in_number    <= in_number_next;
      in_comment   <= in_comment_next;
      acc          <= acc_next;
      width_store  <= width_store_next;
      height_store <= height_store_next;
      pixels_left  <= pixels_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stream.ready) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
        if (produce) begin
          out_data <= res;
        end
      end
    end else if (produce) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= res;
      end
    end
  end

  assign out_stream.valid        = out_valid;
  assign out_stream.result_kind  = out_data.result_kind;
  assign out_stream.image_width  = out_data.image_width;
  assign out_stream.image_height = out_data.image_height;
  assign out_stream.pixel_value  = out_data.pixel_value;
  assign out_stream.last_pixel   = out_data.last_pixel;
  assign out_stream.error_code   = out_data.error_code;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a beat while the output slot is empty");

  a_pixels_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PIXELS) |-> (pixels_left != '0))
    else $error("pixel phase with no pixels left");

  a_eof_rearms: assert property (@(posedge clk) disable iff (rst)
    (accept && in_stream.end_of_file) |=> (phase == PH_MAGIC0) && (acc == '0))
    else $error("end of file did not re-arm the parser");

  a_width_stored: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_HEADER) && (field_idx != FLD_WIDTH)) |-> (width_store != '0))
    else $error("later header field reached without a valid width");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for pgm_p5_stream_parser_unit: feeds directed and random PGM P5 byte streams and
// checks every result beat against a parser model kept in a small scoreboard class.
// Depends on pgmp5_pkg, the stream interfaces in pgmp5_if.sv and the parser top level.
module testbench;
  import pgmp5_pkg::*;

  localparam int DIM_BITS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [7:0] CHAR_VT = 8'h0B;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_X = 8'h78;

  class pgm_header_pixel_checker;
    phase_t phase;
    field_t field_idx;
    bit in_num;
    bit in_cmt;
    logic [ACC_W-1:0] acc;
    logic [15:0] width_q;
    logic [15:0] height_q;
    logic [31:0] pix_left;
    logic [31:0] dim_max;
    result_t pending_results[$];
    int errors;
    int beats;

    function new(int unsigned dim_bits);
      dim_max = (32'd1 << dim_bits) - 32'd1;
      errors = 0;
      beats = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      phase = PH_MAGIC0;
      field_idx = FLD_WIDTH;
      in_num = 0;
      in_cmt = 0;
      acc = '0;
      width_q = '0;
      height_q = '0;
      pix_left = '0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function bit maxval_fits(logic [ACC_W-1:0] v);
      return v != 0 && v <= MAXVAL_MAX;
    endfunction

    function void push(kind_t k, logic [15:0] w, logic [15:0] h, logic [7:0] p, logic l,
                       err_t e);
      result_t r;
      r.result_kind = k;
      r.image_width = w;
      r.image_height = h;
      r.pixel_value = p;
      r.last_pixel = l;
      r.error_code = e;
      pending_results.push_back(r);
    endfunction

    function void push_error(err_t e);
      push(KIND_ERROR, '0, '0, '0, 1'b0, e);
      phase = PH_IDLE;
    endfunction

    function void end_number();
      logic [ACC_W-1:0] v;
      v = acc;
      in_num = 0;
      acc = '0;
      case (field_idx)
        FLD_WIDTH: begin
          if (v == 0 || v > dim_max) push_error(ERR_RANGE);
          else begin
            width_q = v[15:0];
            field_idx = FLD_HEIGHT;
          end
        end
        FLD_HEIGHT: begin
          if (v == 0 || v > dim_max) push_error(ERR_RANGE);
          else begin
            height_q = v[15:0];
            field_idx = FLD_MAXVAL;
          end
        end
        default: begin
          if (!maxval_fits(v)) push_error(ERR_RANGE);
          else begin
            field_idx = FLD_WIDTH;
            pix_left = {16'b0, width_q} * {16'b0, height_q};
            phase = PH_PIXELS;
            push(KIND_HEADER, width_q, height_q, '0, 1'b0, ERR_MAGIC);
          end
        end
      endcase
    endfunction

    function void take_byte(logic [7:0] c, logic eof);
      logic [31:0] sum;
      if (eof) begin
        case (phase)
          PH_MAGIC0, PH_MAGIC1: push_error(ERR_MAGIC);
          PH_HEADER: begin
            if (in_num && field_idx == FLD_MAXVAL)
              push_error(maxval_fits(acc) ? ERR_SHORT : ERR_RANGE);
            else
              push_error(ERR_TOKEN);
          end
          PH_PIXELS: push_error(ERR_SHORT);
          default: ;
        endcase
        clear_parser();
        return;
      end
      case (phase)
        PH_MAGIC0: begin
          if (c == CHAR_P) phase = PH_MAGIC1;
          else push_error(ERR_MAGIC);
        end
        PH_MAGIC1: begin
          if (c == CHAR_5) phase = PH_HEADER;
          else push_error(ERR_MAGIC);
        end
        PH_HEADER: begin
          if (in_num) begin
            if (c >= CHAR_0 && c <= CHAR_9) begin
              sum = {15'b0, acc} * 32'd10 + {24'b0, c - CHAR_0};
              acc = (sum > {15'b0, ACC_MAX}) ? ACC_MAX : sum[ACC_W-1:0];
            end else begin
              end_number();
            end
          end else if (in_cmt) begin
            if (c == CHAR_LF) in_cmt = 0;
          end else if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
          end else if (c == CHAR_HASH) begin
            in_cmt = 1;
          end else if (c >= CHAR_0 && c <= CHAR_9) begin
            in_num = 1;
            acc = {9'b0, c - CHAR_0};
          end else begin
            push_error(ERR_TOKEN);
          end
        end
        PH_PIXELS: begin
          pix_left = pix_left - 32'd1;
          push(KIND_PIXEL, '0, '0, c, pix_left == 0, ERR_MAGIC);
          if (pix_left == 0) phase = PH_IDLE;
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("error: %s", msg);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result beat %0d %s: got %0h, want %0h", beats, name, got, want));
    endtask

    task check_result_beat(result_t got);
      result_t want;
      beats++;
      if (pending_results.size() == 0) begin
        report($sformatf("result beat %0d arrived with nothing outstanding", beats));
        return;
      end
      want = pending_results.pop_front();
      check_field("result_kind", 16'(got.result_kind), 16'(want.result_kind));
      check_field("image_width", got.image_width, want.image_width);
      check_field("image_height", got.image_height, want.image_height);
      check_field("pixel_value", 16'(got.pixel_value), 16'(want.pixel_value));
      check_field("last_pixel", 16'(got.last_pixel), 16'(want.last_pixel));
      check_field("error_code", 16'(got.error_code), 16'(want.error_code));
    endtask
  endclass

  typedef struct {
    logic [7:0] data;
    bit eof;
    bit hold;
  } byte_item_t;

  logic clk;
  logic rst;
  int cycles;
  result_t out_beat;
  byte_item_t file_items[$];
  logic [7:0] file_bytes[$];
  pgm_header_pixel_checker score = new(DIM_BITS);

  pgmp5_in_if in_if ();
  pgmp5_out_if out_if ();

  pgm_p5_stream_parser_unit #(.DIM_BITS(DIM_BITS)) uut (
    .clk(clk),
    .rst(rst),
    .in_stream(in_if),
    .out_stream(out_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void put_byte(logic [7:0] b);
    file_bytes.push_back(b);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endfunction

  function automatic void put_number(int unsigned v);
    put_text($sformatf("%0d", v));
  endfunction

  function automatic void put_hold();
    byte_item_t s;
    s.data = '0;
    s.eof = 0;
    s.hold = 1;
    file_items.push_back(s);
  endfunction

  function automatic void end_file(int keep = -1);
    byte_item_t s;
    s.eof = 0;
    s.hold = 0;
    for (int i = 0; i < file_bytes.size() && (keep < 0 || i < keep); i++) begin
      s.data = file_bytes[i];
      file_items.push_back(s);
    end
    s.data = 8'($urandom_range(0, 255));
    s.eof = 1;
    file_items.push_back(s);
    file_bytes.delete();
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 5))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      2: return CHAR_LF;
      3: return CHAR_VT;
      4: return CHAR_FF;
      default: return CHAR_CR;
    endcase
  endfunction

  function automatic void put_gap();
    int n;
    logic [7:0] b;
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) put_byte(rand_space());
      else begin
        put_byte(CHAR_HASH);
        repeat ($urandom_range(0, 6)) begin
          b = 8'($urandom_range(0, 255));
          if (b == CHAR_LF) b = CHAR_SPACE;
          put_byte(b);
        end
        put_byte(CHAR_LF);
      end
    end
  endfunction

  function automatic void put_number_end();
    logic [7:0] b;
    if ($urandom_range(0, 4) != 0) b = rand_space();
    else begin
      b = 8'($urandom_range(0, 255));
      if (b >= CHAR_0 && b <= CHAR_9) b = b + 8'h10;
    end
    put_byte(b);
  endfunction

  function automatic int unsigned rand_dim();
    if ($urandom_range(0, 19) == 0) return $urandom_range(7, 40);
    return $urandom_range(1, 6);
  endfunction

  function automatic void build_directed();
    end_file();
    put_text("P");
    end_file();
    put_text("Qx5");
    end_file();
    put_text("P6 1 1 1 A");
    end_file();
    put_text("P5");
    put_byte(CHAR_TAB);
    put_byte(CHAR_LF);
    put_byte(CHAR_VT);
    put_byte(CHAR_FF);
    put_byte(CHAR_CR);
    put_text(" 2 2 255");
    put_byte(CHAR_LF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h80);
    put_byte(8'h7F);
    put_text("zz");
    end_file();
    put_text("P5 #");
    put_byte(8'hFF);
    put_byte(8'h80);
    put_text(" note");
    put_byte(CHAR_LF);
    put_text("1#2 1");
    put_byte(CHAR_CR);
    put_byte(8'h11);
    put_byte(8'h22);
    end_file();
    put_text("P5 1a1b1c");
    put_byte(8'h01);
    end_file();
    put_text("P5 x");
    end_file();
    put_text("P5 0 ");
    end_file();
    put_text("P5 65536 ");
    end_file();
    put_text("P5 99999999 ");
    end_file();
    put_text("P5 65535 0 ");
    end_file();
    put_text("P5 1 1 0 ");
    end_file();
    put_text("P5 1 1 256 ");
    end_file();
    put_text("P5 1 1 00255 ");
    put_byte(8'hAA);
    end_file();
    put_text("P5 2 2 25");
    end_file();
    put_text("P5 2 2 300");
    end_file();
    put_text("P5 1");
    end_file();
    put_text("P5 2 2 ");
    end_file();
    put_text("P5 #abc");
    end_file();
    put_text("P5");
    end_file();
    put_text("P5 65535 1 255 ");
    put_text("abc");
    end_file();
    put_text("P5 1 65535 255");
    put_byte(CHAR_LF);
    end_file();
    put_hold();
    put_text("P5 3 1 9 ");
    put_byte(8'h00);
    put_byte(8'h55);
    put_byte(8'hFF);
    end_file();
  endfunction

  function automatic void build_random(int target);
    int kind;
    int sub;
    int bad_field;
    int token_at;
    int hdr_len;
    int npix;
    int unsigned vals[3];
    logic [7:0] b;
    while (file_items.size() < target) begin
      if ($urandom_range(0, 24) == 0) put_hold();
      kind = $urandom_range(0, 99);
      if (kind >= 88) begin
        repeat ($urandom_range(1, 16)) begin
          if ($urandom_range(0, 3) == 0) put_text("P5");
          put_byte(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 7) == 0) end_file();
        end
        end_file();
      end else if (kind >= 80) begin
        if ($urandom_range(0, 1) == 0) begin
          b = 8'($urandom_range(0, 255));
          if (b == CHAR_P) b = CHAR_X;
          put_byte(b);
        end else begin
          put_byte(CHAR_P);
          b = 8'($urandom_range(0, 255));
          if (b == CHAR_5) b = CHAR_X;
          put_byte(b);
        end
        repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
        end_file();
      end else begin
        vals[0] = rand_dim();
        vals[1] = rand_dim();
        vals[2] = $urandom_range(1, 255);
        sub = (kind >= 72) ? $urandom_range(0, 2) : 3;
        bad_field = -1;
        token_at = -1;
        if (sub == 0) begin
          bad_field = $urandom_range(0, 2);
          if ($urandom_range(0, 2) == 0) vals[bad_field] = 0;
          else if (bad_field == 2) vals[bad_field] = $urandom_range(256, 99999);
          else vals[bad_field] = $urandom_range(65536, 999999999);
        end else if (sub == 1) begin
          token_at = $urandom_range(0, 2);
        end
        put_text("P5");
        for (int f = 0; f < 3; f++) begin
          put_gap();
          if (f == token_at) begin
            b = 8'($urandom_range(0, 255));
            if (b <= CHAR_SPACE || (b >= CHAR_0 && b <= CHAR_9) || b == CHAR_HASH) b = CHAR_X;
            put_byte(b);
          end
          if ($urandom_range(0, 9) == 0) put_text("0");
          put_number(vals[f]);
          put_number_end();
        end
        hdr_len = file_bytes.size();
        npix = (sub >= 2) ? vals[0] * vals[1] : $urandom_range(0, 3);
        repeat (npix) put_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
        if (sub == 2) end_file($urandom_range(0, hdr_len - 1));
        else if (sub == 3 && $urandom_range(0, 9) == 0) end_file(hdr_len + $urandom_range(0, npix - 1));
        else end_file();
      end
    end
  endfunction

  task automatic drive_stream();
    int k;
    int burst;
    int gap;
    k = 0;
    burst = 0;
    while (k < file_items.size()) begin
      if (file_items[k].hold) begin
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (score.pending() != 0) @(posedge clk);
        k++;
        continue;
      end
      if (burst == 0) begin
        burst = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 60);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_if.valid <= 1'b1;
      in_if.data_byte <= file_items[k].data;
      in_if.end_of_file <= file_items[k].eof;
      @(posedge clk);
      while (!in_if.ready) @(posedge clk);
      k++;
      burst--;
    end
    in_if.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_if.valid && in_if.ready) score.take_byte(in_if.data_byte, in_if.end_of_file);
      if (out_if.valid && out_if.ready) begin
        out_beat.result_kind = out_if.result_kind;
        out_beat.image_width = out_if.image_width;
        out_beat.image_height = out_if.image_height;
        out_beat.pixel_value = out_if.pixel_value;
        out_beat.last_pixel = out_if.last_pixel;
        out_beat.error_code = out_if.error_code;
        score.check_result_beat(out_beat);
      end
    end
  end

  initial begin
    int mode;
    int left;
    int tick;
    bit held;
    out_if.ready <= 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    held = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && score.beats >= 150) begin
        held = 1;
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      tick++;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= (tick % 3) != 0;
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
      @(posedge clk);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("pgm_p5_stream_parser_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int directed_len;
    rst <= 1'b1;
    in_if.valid <= 1'b0;
    in_if.data_byte <= '0;
    in_if.end_of_file <= 1'b0;
    build_directed();
    directed_len = file_items.size();
    build_random(directed_len + 2000);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    drive_stream();
    while (score.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (score.errors == 0) begin
      $display("pgm_p5_stream_parser_unit: match");
    end else begin
      $display("pgm_p5_stream_parser_unit: mismatch");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/pgmp5_pkg.sv
rtl/core/pgmp5_if.sv
rtl/core/pgm_p5_stream_parser_unit.sv
tb/sv/testbench.sv
